// File: rtl/sacts_pkg.sv
// Shared types and constants for the set-associative cache tag store.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
package sacts_pkg;

	// Item opcodes.
	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_DIRTY  = 2'd2,
		OP_TOUCH  = 2'd3
	} op_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_OFFSET_WIDTH = 2'd0;
	localparam logic [1:0] CFG_INDEX_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_REPLACE_MODE = 2'd2;

	// Replacement policies.
	localparam logic MODE_LRU  = 1'b0;
	localparam logic MODE_FIFO = 1'b1;

	// Decoded set index is at most 15 bits wide (4-bit index width register).
	localparam int IDX_W = 15;

	localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

endpackage

// File: rtl/sacts_row_mem.sv
// Synchronous single-port-write, single-port-read memory with a registered read.
// No dependencies; holds one cache set per row.
`timescale 1ns / 1ps
module sacts_row_mem #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/set_assoc_cache_tag_store.sv
// Top level of the set-associative write-back cache tag store.
// Depends on sacts_pkg and sacts_row_mem.
//
// Channel   Direction  Handshake             Payload
// cfg       in         cfg_we                cfg_index, cfg_data
// in        in         in_valid / in_stall   opcode, address, way_select, time_stamp
// out       out        out_valid / out_stall hit, hit_way, writeback_flag,
//                                            writeback_address, eviction_total,
//                                            writeback_total
//
// Each item passes through the read state, a per-way scan for lookup and insert, and
// the write state, with a set-index reduction (quotient, then remainder) first when
// SETS_MAX is not a power of two; the write state waits until the output register is free.
// After reset a clearing pass writes SETS_MAX rows, one per cycle, before the
// first item is taken. A finished result waits in the output register while
// the next item is accepted; an item completes only once that register is free.
`timescale 1ns / 1ps
module set_assoc_cache_tag_store
	import sacts_pkg::*;
#(
	parameter int WAYS      = 8,
	parameter int SETS_MAX  = 1024,
	parameter int ADDR_BITS = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [47:0] address,
	input  logic [2:0]  way_select,
	input  logic [63:0] time_stamp,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic [2:0]  hit_way,
	output logic        writeback_flag,
	output logic [47:0] writeback_address,
	output logic [31:0] eviction_total,
	output logic [31:0] writeback_total
);

	localparam int  SI_W  = (SETS_MAX > 1) ? $clog2(SETS_MAX) : 1;
	localparam int  WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam bit  POW2  = ((SETS_MAX & (SETS_MAX - 1)) == 0);
	localparam logic [47:0] AMASK =
		(ADDR_BITS >= 48) ? {48{1'b1}} : ((48'd1 << ADDR_BITS) - 48'd1);
	localparam logic [31:0] SETS_MASK = 32'(SETS_MAX - 1);

	// Reciprocal of SETS_MAX, exact for every decoded set index.
	localparam int          RSH     = IDX_W + SI_W;
	localparam logic [63:0] RECIP64 =
		((64'd1 << RSH) + 64'(SETS_MAX) - 64'd1) / 64'(SETS_MAX);
	localparam logic [31:0] RECIP   = RECIP64[31:0];

	typedef struct packed {
		logic        valid;
		logic        dirty;
		logic [47:0] tag;
		logic [63:0] used_ts;
		logic [63:0] inserted;
	} line_t;

	typedef line_t [WAYS-1:0] row_t;
	localparam int ROW_W = $bits(row_t);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_READ,
		ST_SCAN,
		ST_WRITE
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [3:0] ow_q;
	logic [3:0] iw_q;
	logic       mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ow_q   <= 4'd6;
			iw_q   <= 4'd6;
			mode_q <= MODE_LRU;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OFFSET_WIDTH: ow_q   <= cfg_data;
				CFG_INDEX_WIDTH:  iw_q   <= cfg_data;
				CFG_REPLACE_MODE: mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Address decode of the incoming item.
	logic [47:0]      addr_m;
	logic [47:0]      idx_full;
	logic [IDX_W-1:0] set_in;
	logic [47:0]      tag_in;
	logic [14:0]      idx_mask;

	always_comb begin
		addr_m   = address & AMASK;
		idx_mask = 15'((16'd1 << iw_q) - 16'd1);
		idx_full = addr_m >> ow_q;
		set_in   = idx_full[IDX_W-1:0] & idx_mask;
		tag_in   = addr_m >> (5'(ow_q) + 5'(iw_q));
	end

	// Item registers.
	op_t              op_q;
	logic [IDX_W-1:0] set_q;
	logic [47:0]      tag_q;
	logic [2:0]       way_q;
	logic [63:0]      ts_q;
	logic [15:0]      rem_q;
	logic             mod_ph_q;
	logic [IDX_W-1:0] quo_q;
	logic [SI_W-1:0]  clr_q;

	// Scan registers.
	logic [WW-1:0]    w_q;
	logic             found_q;
	logic [WW-1:0]    sel_q;
	logic [WW-1:0]    best_q;
	logic [63:0]      best_val_q;

	// Counters.
	logic [31:0] evict_q;
	logic [31:0] wb_q;

	// Memory interface.
	logic            mem_we;
	logic [SI_W-1:0] mem_waddr;
	row_t            mem_wdata;
	logic            mem_re;
	row_t            mem_rdata;
	logic [ROW_W-1:0] mem_rdata_raw;

	sacts_row_mem #(
		.WIDTH (ROW_W),
		.DEPTH (SETS_MAX),
		.ADDR_W(SI_W)
	) u_row_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(rem_q[SI_W-1:0]),
		.rdata(mem_rdata_raw)
	);

	assign mem_rdata = row_t'(mem_rdata_raw);

	// Set index reduction: quotient by reciprocal, then remainder.
	logic [31:0] quo_prod;
	logic [31:0] rem_prod;
	assign quo_prod = 32'(set_q) * RECIP;
	assign rem_prod = 32'(quo_q) * 32'(SETS_MAX);

	// Current way under scan and its replacement key.
	line_t       scan_line;
	logic [63:0] scan_key;
	always_comb begin
		scan_line = mem_rdata[w_q];
		scan_key  = (mode_q == MODE_FIFO) ? scan_line.inserted : scan_line.used_ts;
	end

	// Result of the item, computed from the read row.
	logic          out_free;
	logic          way_ok;
	logic [WW-1:0] way_idx;
	logic [WW-1:0] victim;
	line_t         vline;
	row_t          new_row;
	logic          do_write;
	logic          r_hit;
	logic [2:0]    r_way;
	logic          r_wflag;
	logic [47:0]   r_waddr;
	logic [31:0]   r_evict;
	logic [31:0]   r_wb;
	logic [63:0]   wb_tmp;
	logic [31:0]   way_ext;

	assign out_free = !out_valid || !out_stall;

	always_comb begin
		way_ok   = 32'(way_q) < WAYS;
		way_ext  = 32'(way_q);
		way_idx  = way_ext[WW-1:0];
		victim   = found_q ? sel_q : best_q;
		vline    = mem_rdata[victim];
		new_row  = mem_rdata;
		do_write = 1'b0;
		r_hit    = 1'b0;
		r_way    = 3'd0;
		r_wflag  = 1'b0;
		r_waddr  = 48'd0;
		r_evict  = evict_q;
		r_wb     = wb_q;
		wb_tmp   = (({16'd0, vline.tag} << iw_q) | 64'(set_q)) << ow_q;
		unique case (op_q)
			OP_LOOKUP: begin
				r_hit = found_q;
				r_way = found_q ? 3'(32'(sel_q)) : 3'd0;
			end
			OP_INSERT: begin
				r_way    = 3'(32'(victim));
				do_write = 1'b1;
				if (vline.valid) begin
					r_evict = (evict_q == CNT_MAX) ? evict_q : evict_q + 32'd1;
					if (vline.dirty) begin
						r_wb    = (wb_q == CNT_MAX) ? wb_q : wb_q + 32'd1;
						r_wflag = 1'b1;
						r_waddr = wb_tmp[47:0];
					end
				end
				new_row[victim].valid    = 1'b1;
				new_row[victim].dirty    = 1'b0;
				new_row[victim].tag      = tag_q;
				new_row[victim].used_ts  = ts_q;
				new_row[victim].inserted = ts_q;
			end
			// Mark dirty and touch on a way beyond the set width do nothing.
			OP_DIRTY: begin
				if (way_ok) begin
					do_write = 1'b1;
					new_row[way_idx].dirty = 1'b1;
				end
			end
			OP_TOUCH: begin
				if (way_ok) begin
					do_write = 1'b1;
					new_row[way_idx].used_ts = ts_q;
				end
			end
			default: ;
		endcase
	end

	// Memory write: clearing pass or write-back of the modified row.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rem_q[SI_W-1:0];
		mem_wdata = new_row;
		mem_re    = (state_q == ST_READ);
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (state_q == ST_WRITE && out_free && do_write) begin
			mem_we = 1'b1;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	// Sequencer with output register and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			out_valid <= 1'b0;
			evict_q   <= '0;
			wb_q      <= '0;
			mod_ph_q  <= 1'b0;
			w_q       <= '0;
			found_q   <= 1'b0;
		end else begin
			// The output register fills on completion and empties on a transfer.
			if (state_q == ST_WRITE && out_free) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SI_W'(SETS_MAX - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						op_q     <= op_t'(opcode);
						set_q    <= set_in;
						tag_q    <= tag_in;
						way_q    <= way_select;
						ts_q     <= time_stamp;
						mod_ph_q <= 1'b1;
						if (POW2) begin
							rem_q   <= 16'(32'(set_in) & SETS_MASK);
							state_q <= ST_READ;
						end else begin
							rem_q   <= {1'b0, set_in};
							state_q <= ST_MOD;
						end
					end
				end
				ST_MOD: begin
					if (mod_ph_q) begin
						quo_q    <= IDX_W'(quo_prod >> RSH);
						mod_ph_q <= 1'b0;
					end else begin
						rem_q   <= 16'(32'(set_q) - rem_prod);
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					w_q     <= '0;
					found_q <= 1'b0;
					state_q <= (op_q == OP_LOOKUP || op_q == OP_INSERT) ? ST_SCAN : ST_WRITE;
				end
				ST_SCAN: begin
					if (!found_q) begin
						if (op_q == OP_LOOKUP) begin
							if (scan_line.valid && scan_line.tag == tag_q) begin
								found_q <= 1'b1;
								sel_q   <= w_q;
							end
						end else if (!scan_line.valid) begin
							found_q <= 1'b1;
							sel_q   <= w_q;
						end
					end
					if (w_q == '0 || scan_key < best_val_q) begin
						best_q     <= w_q;
						best_val_q <= scan_key;
					end
					w_q <= w_q + 1'b1;
					if (w_q == WW'(WAYS - 1)) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (out_free) begin
						hit               <= r_hit;
						hit_way           <= r_way;
						writeback_flag    <= r_wflag;
						writeback_address <= r_waddr;
						eviction_total    <= r_evict;
						writeback_total   <= r_wb;
						evict_q           <= r_evict;
						wb_q              <= r_wb;
						state_q           <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: verif/set_assoc_cache_tag_store_tb.sv
// Self-checking testbench for the set-associative cache tag store.
// Depends on sacts_pkg and the set_assoc_cache_tag_store top level.
`timescale 1ns / 1ps
module set_assoc_cache_tag_store_tb
	import sacts_pkg::*;
();

	localparam int NWAYS     = 8;
	localparam int NSETS     = 1024;
	localparam int NROWS     = NWAYS * NSETS;
	localparam int CYCLE_CAP = 600000;

	typedef struct {
		op_t         op;
		logic [47:0] addr;
		logic [2:0]  way;
		logic [63:0] ts;
	} cache_req_t;

	typedef struct packed {
		logic        hit;
		logic [2:0]  way;
		logic        wb;
		logic [47:0] wb_addr;
		logic [31:0] evictions;
		logic [31:0] writebacks;
	} tag_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = 2'd0;
	logic [3:0]  cfg_data = 4'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  opcode = 2'd0;
	logic [47:0] address = 48'd0;
	logic [2:0]  way_select = 3'd0;
	logic [63:0] time_stamp = 64'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        hit;
	logic [2:0]  hit_way;
	logic        writeback_flag;
	logic [47:0] writeback_address;
	logic [31:0] eviction_total;
	logic [31:0] writeback_total;

	set_assoc_cache_tag_store u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .address(address), .way_select(way_select),
		.time_stamp(time_stamp),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .hit_way(hit_way), .writeback_flag(writeback_flag),
		.writeback_address(writeback_address),
		.eviction_total(eviction_total), .writeback_total(writeback_total)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Shadow copy of the tag store and its registers.
	logic        shd_valid [NROWS];
	logic        shd_dirty [NROWS];
	logic [63:0] shd_tag [NROWS];
	logic [63:0] shd_used [NROWS];
	logic [63:0] shd_ins [NROWS];
	logic [31:0] shd_evictions = 32'd0;
	logic [31:0] shd_writebacks = 32'd0;
	int          shd_off_w = 6;
	int          shd_idx_w = 6;
	logic        shd_mode = MODE_LRU;

	cache_req_t  req_q [$];
	tag_result_t expected_q [$];
	int          err_count = 0;
	int          cycle_count = 0;
	logic [63:0] now_ts = 64'd100;

	initial begin
		for (int i = 0; i < NROWS; i++) begin
			shd_valid[i] = 1'b0;
			shd_dirty[i] = 1'b0;
		end
	end

	// Computes the result of one request and updates the shadow store.
	function automatic tag_result_t tag_store_step(cache_req_t rq);
		logic [63:0] set_idx;
		logic [63:0] tg;
		logic [63:0] ka;
		logic [63:0] kb;
		logic [63:0] wa;
		int          base;
		int          vic;
		tag_result_t r;
		r = '0;
		set_idx = (64'(rq.addr) >> shd_off_w) & ((64'd1 << shd_idx_w) - 64'd1);
		tg = 64'(rq.addr) >> (shd_off_w + shd_idx_w);
		base = int'(set_idx % NSETS) * NWAYS;
		if (rq.op == OP_LOOKUP) begin
			for (int w = NWAYS - 1; w >= 0; w--) begin
				if (shd_valid[base + w] && shd_tag[base + w] == tg) begin
					r.hit = 1'b1;
					r.way = 3'(w);
				end
			end
		end else if (rq.op == OP_INSERT) begin
			// Lowest invalid way first, else oldest time with ties to the lowest way.
			vic = -1;
			for (int w = 0; w < NWAYS; w++)
				if (vic < 0 && !shd_valid[base + w])
					vic = w;
			if (vic < 0) begin
				vic = 0;
				for (int w = 1; w < NWAYS; w++) begin
					ka = shd_mode ? shd_ins[base + w] : shd_used[base + w];
					kb = shd_mode ? shd_ins[base + vic] : shd_used[base + vic];
					if (ka < kb)
						vic = w;
				end
			end
			r.way = 3'(vic);
			if (shd_valid[base + vic]) begin
				if (shd_evictions != CNT_MAX)
					shd_evictions++;
				if (shd_dirty[base + vic]) begin
					if (shd_writebacks != CNT_MAX)
						shd_writebacks++;
					r.wb = 1'b1;
					wa = ((shd_tag[base + vic] << shd_idx_w) | set_idx) << shd_off_w;
					r.wb_addr = wa[47:0];
				end
			end
			shd_tag[base + vic] = tg;
			shd_valid[base + vic] = 1'b1;
			shd_dirty[base + vic] = 1'b0;
			shd_used[base + vic] = rq.ts;
			shd_ins[base + vic] = rq.ts;
		end else if (rq.op == OP_DIRTY) begin
			shd_dirty[base + rq.way] = 1'b1;
		end else begin
			shd_used[base + rq.way] = rq.ts;
		end
		r.evictions = shd_evictions;
		r.writebacks = shd_writebacks;
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("Mismatch on %s at cycle %0d: got 0x%0h, expected 0x%0h",
			field, cycle_count, got, want);
		err_count++;
	endtask

	// Driver: sends queued requests in bursts and records predictions on each transfer.
	int burst_left = 4;
	int gap_left = 0;
	always @(posedge clk) begin
		cache_req_t rq;
		logic nv;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				rq.op = op_t'(opcode);
				rq.addr = address;
				rq.way = way_select;
				rq.ts = time_stamp;
				expected_q.push_back(tag_store_step(rq));
			end
			if (!in_valid || !in_stall) begin
				nv = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (req_q.size() > 0) begin
					rq = req_q.pop_front();
					opcode <= rq.op;
					address <= rq.addr;
					way_select <= rq.way;
					time_stamp <= rq.ts;
					nv = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
					end
				end
				in_valid <= nv;
			end
		end
	end

	// Receiver stall pattern: switches among four styles of stall, from none to heavy.
	int stall_style = 0;
	always @(posedge clk) begin
		if (cycle_count % 300 == 0)
			stall_style = $urandom_range(0, 3);
		case (stall_style)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 9) < 3);
			2: out_stall <= ((cycle_count % 23) < 9);
			default: out_stall <= ($urandom_range(0, 9) < 8);
		endcase
	end

	// Monitor: compares each result transfer with the oldest prediction.
	always @(posedge clk) begin
		tag_result_t want;
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Verification failed");
			$finish;
		end else if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result", 64'd1, 64'd0);
			end else begin
				want = expected_q.pop_front();
				if (hit !== want.hit)
					report_mismatch("hit", 64'(hit), 64'(want.hit));
				if (hit_way !== want.way)
					report_mismatch("hit_way", 64'(hit_way), 64'(want.way));
				if (writeback_flag !== want.wb)
					report_mismatch("writeback_flag", 64'(writeback_flag), 64'(want.wb));
				if (writeback_address !== want.wb_addr)
					report_mismatch("writeback_address", 64'(writeback_address),
						64'(want.wb_addr));
				if (eviction_total !== want.evictions)
					report_mismatch("eviction_total", 64'(eviction_total),
						64'(want.evictions));
				if (writeback_total !== want.writebacks)
					report_mismatch("writeback_total", 64'(writeback_total),
						64'(want.writebacks));
			end
		end
	end

	// Builds a byte address from tag, set and offset under the current field split.
	function automatic logic [47:0] make_addr(logic [63:0] tg, logic [63:0] set_idx,
		logic [63:0] off);
		logic [63:0] a;
		a = (tg << (shd_off_w + shd_idx_w))
			| ((set_idx & ((64'd1 << shd_idx_w) - 1)) << shd_off_w)
			| (off & ((64'd1 << shd_off_w) - 1));
		return a[47:0];
	endfunction

	task automatic add_req(op_t op, logic [47:0] a, logic [2:0] w, logic [63:0] ts);
		cache_req_t rq;
		rq.op = op;
		rq.addr = a;
		rq.way = w;
		rq.ts = ts;
		req_q.push_back(rq);
	endtask

	// Drives one register write and updates the shadow field; the caller drops the write enable.
	task automatic write_reg(logic [1:0] idx, logic [3:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_OFFSET_WIDTH: shd_off_w = val;
			CFG_INDEX_WIDTH:  shd_idx_w = val;
			default:          shd_mode = val[0];
		endcase
	endtask

	task automatic set_config(int ow, int iw, logic mode);
		@(posedge clk);
		write_reg(CFG_OFFSET_WIDTH, 4'(ow));
		write_reg(CFG_INDEX_WIDTH, 4'(iw));
		write_reg(CFG_REPLACE_MODE, {3'd0, mode});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		while (req_q.size() > 0 || expected_q.size() > 0 || in_valid)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Mostly well-formed traffic on a few crowded sets, with some noise.
	task automatic add_random(int count);
		logic [63:0] set_idx;
		logic [63:0] ts;
		op_t op;
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				add_req(op_t'($urandom_range(0, 3)), 48'({$urandom, $urandom}),
					3'($urandom), {$urandom, $urandom});
			end else begin
				set_idx = 64'($urandom_range(0, 3));
				if (shd_idx_w > 10 && $urandom_range(0, 1))
					set_idx += NSETS;
				if (pick < 40)
					op = OP_LOOKUP;
				else if (pick < 70)
					op = OP_INSERT;
				else if (pick < 83)
					op = OP_DIRTY;
				else
					op = OP_TOUCH;
				now_ts += $urandom_range(0, 3);
				ts = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(0, 200)) : now_ts;
				add_req(op, make_addr(64'($urandom_range(0, 11)), set_idx, 64'($urandom)),
					3'($urandom), ts);
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset split, with all registers written.
		set_config(6, 6, MODE_LRU);
		add_req(OP_LOOKUP, make_addr(5, 0, 0), 3'd0, 64'd0);
		for (int w = 0; w < NWAYS; w++)
			add_req(OP_INSERT, make_addr(w, 0, w), 3'd0, 64'd50);
		add_req(OP_DIRTY, 48'd0, 3'd0, 64'd0);
		add_req(OP_TOUCH, 48'd0, 3'd1, 64'hFFFF_FFFF_FFFF_FFFF);
		add_req(OP_INSERT, make_addr(20, 0, 0), 3'd0, 64'd60);
		add_req(OP_INSERT, make_addr(21, 0, 0), 3'd0, 64'd61);
		add_req(OP_LOOKUP, make_addr(3, 0, 63), 3'd7, 64'd0);
		add_req(OP_LOOKUP, make_addr(20, 0, 1), 3'd0, 64'd0);
		add_req(OP_DIRTY, make_addr(0, 5, 0), 3'd4, 64'd0);
		add_req(OP_INSERT, make_addr(9, 5, 0), 3'd0, 64'd70);
		add_req(OP_INSERT, 48'hFFFF_FFFF_FFFF, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
		add_req(OP_DIRTY, 48'hFFFF_FFFF_FFFF, 3'd0, 64'd0);
		add_req(OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 3'd7, 64'd0);
		add_req(OP_TOUCH, 48'hFFFF_FFFF_FFFF, 3'd0, 64'd0);
		add_req(OP_INSERT, 48'h0, 3'd0, 64'd0);
		wait_idle();

		// Random phases across field splits and both replacement policies.
		set_config(6, 6, MODE_LRU);
		add_random(210);
		wait_idle();
		set_config(0, 0, MODE_FIFO);
		add_random(200);
		wait_idle();
		set_config(12, 10, MODE_LRU);
		add_random(210);
		wait_idle();
		set_config(15, 15, MODE_FIFO);
		add_random(200);
		wait_idle();
		set_config(3, 2, MODE_FIFO);
		add_random(210);
		wait_idle();
		set_config(6, 12, MODE_LRU);
		add_random(200);
		wait_idle();

		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: files.f
rtl/sacts_pkg.sv
rtl/sacts_row_mem.sv
rtl/set_assoc_cache_tag_store.sv
verif/set_assoc_cache_tag_store_tb.sv
